[sv/i2c_bseq_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
package i2c_bseq_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_SEND  = 3'd2;
  localparam logic [2:0] KIND_RECV  = 3'd3;
  localparam logic [2:0] KIND_SACK  = 3'd4;
  localparam logic [2:0] KIND_RACK  = 3'd5;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [2:0] {
    OP_START,
    OP_STOP,
    OP_SEND,
    OP_RECV,
    OP_SACK,
    OP_RACK
  } op_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // data: tx byte, sampled line bits, or ack level in bit 7
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx_byte;
    logic       rx_ack;
    logic       last;
  } res_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_hs_t;

endpackage

[sv/i2c_master_bit_sequencer_top.sv]
// I2C master bit sequencer: one bus command in, its run of SCL/SDA pin writes out.
// The first pin write of a command passes the command queue, the sequencer registers and the result queue.
// Throughput: one pin write per cycle while the result queue has room; runs are 3, 4, 17 or 24 writes.
// Consecutive runs follow with no gap; unused kinds take one input transfer and no results.
// The sequencer emits one write per cycle; the two-entry queues on each side absorb stalls.
// Reset (rst_ni low, async): queues empty, SCL and SDA levels both released (1).
module i2c_master_bit_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // command side
  input  logic       push,
  output logic       full,
  input  logic [2:0] kind_i,
  input  logic [7:0] tx_byte_i,
  input  logic       ack_level_i,
  input  logic [7:0] line_bits_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic       scl_o,
  output logic       sda_o,
  output logic [7:0] rx_byte_o,
  output logic       rx_ack_o,
  output logic       last_o
);
  import i2c_bseq_pkg::*;

  cmd_hs_t cmd;
  logic    cmd_pop;
  res_t    res_wr, res_rd;
  logic    res_push, res_full;

  // front: decode kind, drop unused kinds, hold up to two commands
  i2c_bseq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .kind_i      (kind_i),
    .tx_byte_i   (tx_byte_i),
    .ack_level_i (ack_level_i),
    .line_bits_i (line_bits_i),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: step through the run, tracking the pin levels; takes the next
  // command in the same cycle as the last write of the current one
  i2c_bseq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_full_i (res_full),
    .res_o      (res_wr)
  );

  // result queue decouples the sequencer from pop
  i2c_bseq_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_wr),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_rd)
  );

  assign scl_o     = res_rd.scl;
  assign sda_o     = res_rd.sda;
  assign rx_byte_o = res_rd.rx_byte;
  assign rx_ack_o  = res_rd.rx_ack;
  assign last_o    = res_rd.last;

endmodule

[sv/i2c_bseq_front.sv]
// Front end: decodes command kinds, drops unused ones, queues the rest.
module i2c_bseq_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [2:0]            kind_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  ack_level_i,
  input  logic [7:0]            line_bits_i,
  output i2c_bseq_pkg::cmd_hs_t cmd_o,
  input  logic                  cmd_pop_i
);
  import i2c_bseq_pkg::*;

  cmd_t             entry_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cmd_t             dec_cmd;
  logic             dec_ok;
  logic             wr_en, rd_en;

  // decode kind into an op and the one data byte that op needs
  always_comb begin
    dec_ok       = 1'b1;
    dec_cmd.op   = OP_START;
    dec_cmd.data = 8'h00;
    case (kind_i)
      KIND_START: dec_cmd.op = OP_START;
      KIND_STOP:  dec_cmd.op = OP_STOP;
      KIND_SEND: begin
        dec_cmd.op   = OP_SEND;
        dec_cmd.data = tx_byte_i;
      end
      KIND_RECV: begin
        dec_cmd.op   = OP_RECV;
        dec_cmd.data = line_bits_i;
      end
      KIND_SACK: begin
        dec_cmd.op   = OP_SACK;
        dec_cmd.data = {ack_level_i, 7'b0};
      end
      KIND_RACK: begin
        dec_cmd.op   = OP_RACK;
        dec_cmd.data = line_bits_i;
      end
      default: dec_ok = 1'b0;
    endcase
  end

  assign full_o = (cnt_q == CNT_W'(QDEPTH));
  assign wr_en  = push_i && !full_o && dec_ok;
  assign rd_en  = cmd_pop_i && (cnt_q != '0);

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

[sv/i2c_bseq_back.sv]
// Back end: expands one queued command into its run of pin writes.
module i2c_bseq_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2c_bseq_pkg::cmd_hs_t cmd_i,
  output logic                  cmd_pop_o,
  output logic                  res_push_o,
  input  logic                  res_full_i,
  output i2c_bseq_pkg::res_t    res_o
);
  import i2c_bseq_pkg::*;

  seq_state_e state_q, state_d;
  op_e        op_q;
  logic [7:0] data_q, data_d;
  logic [2:0] bit_q, bit_d;
  logic [1:0] ph_q, ph_d;
  logic       scl_q, sda_q;
  logic       emit, take;
  res_t       wr;

  // pin write for the current step
  always_comb begin
    wr.scl     = scl_q;
    wr.sda     = sda_q;
    wr.rx_byte = 8'h00;
    wr.rx_ack  = 1'b0;
    wr.last    = 1'b0;
    case (op_q)
      OP_START: begin
        case (ph_q)
          2'd0:    wr.sda = 1'b1;
          2'd1:    wr.scl = 1'b1;
          2'd2:    wr.sda = 1'b0;
          default: begin
            wr.scl  = 1'b0;
            wr.last = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (ph_q)
          2'd0:    wr.sda = 1'b0;
          2'd1:    wr.scl = 1'b1;
          default: begin
            wr.sda  = 1'b1;
            wr.last = 1'b1;
          end
        endcase
      end
      default: begin
        // byte and ack ops: SDA write, SCL high, SCL low (send repeats all three per bit, receive the SCL pair)
        case (ph_q)
          2'd0:    wr.sda = (op_q == OP_RECV || op_q == OP_RACK) ? 1'b1 : data_q[7];
          2'd1:    wr.scl = 1'b1;
          default: begin
            wr.scl  = 1'b0;
            wr.last = (op_q == OP_SEND || op_q == OP_RECV) ? (bit_q == LAST_BIT) : 1'b1;
          end
        endcase
        if (wr.last && op_q == OP_RECV) begin
          wr.rx_byte = data_q;
        end
        if (wr.last && op_q == OP_RACK) begin
          wr.rx_ack = data_q[7];
        end
      end
    endcase
  end

  assign emit       = (state_q == SEQ_RUN) && !res_full_i;
  assign take       = cmd_i.valid && ((state_q == SEQ_IDLE) || (emit && wr.last));
  assign cmd_pop_o  = take;
  assign res_push_o = emit;
  assign res_o      = wr;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: if (cmd_i.valid) state_d = SEQ_RUN;
      SEQ_RUN:  if (emit && wr.last && !cmd_i.valid) state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
  end

  // step counters
  always_comb begin
    data_d = data_q;
    bit_d  = bit_q;
    ph_d   = ph_q;
    if (take) begin
      data_d = cmd_i.cmd.data;
      bit_d  = '0;
      ph_d   = '0;
    end else if (emit && !wr.last) begin
      if (ph_q == 2'd2 && op_q == OP_SEND) begin
        ph_d   = 2'd0;
        bit_d  = bit_q + 1'b1;
        data_d = {data_q[6:0], 1'b0};
      end else if (ph_q == 2'd2 && op_q == OP_RECV) begin
        ph_d  = 2'd1;
        bit_d = bit_q + 1'b1;
      end else begin
        ph_d = ph_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      op_q    <= OP_START;
      bit_q   <= '0;
      ph_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      ph_q    <= ph_d;
      if (take) begin
        op_q <= cmd_i.cmd.op;
      end
      if (emit) begin
        scl_q <= wr.scl;
        sda_q <= wr.sda;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[sv/i2c_bseq_out_q.sv]
// Result queue between the sequencer and the result port.
module i2c_bseq_out_q (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  i2c_bseq_pkg::res_t data_i,
  output logic               empty_o,
  input  logic               pop_i,
  output i2c_bseq_pkg::res_t data_o
);
  import i2c_bseq_pkg::*;

  res_t             entry_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/i2c_bseq_chk.sv]
// Port-level checker for the I2C master bit sequencer, with its bind.
module i2c_bseq_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       scl_o,
  input logic       sda_o,
  input logic [7:0] rx_byte_o,
  input logic       rx_ack_o,
  input logic       last_o
);

  // a waiting result stays until it is popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  // received ack only on the closing write of a run
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rx_ack_o) |-> (last_o && !scl_o))
    else $error("rx_ack outside closing write");

  // received byte only on the closing SCL-low write
  a_byte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (rx_byte_o != 8'h00)) |-> (last_o && !scl_o))
    else $error("rx_byte outside closing write");

  // a run that ends with SCL high is a stop and leaves SDA released
  a_stop_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o && scl_o) |-> sda_o)
    else $error("run ended with SCL high and SDA low");

endmodule

bind i2c_master_bit_sequencer_top i2c_bseq_chk u_chk (.*);

[sim/i2c_master_bit_sequencer_top_test.sv]
// Self-checking testbench for the I2C master bit sequencer: bus commands in, pin writes out.
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_top_test;
  import i2c_bseq_pkg::*;

  // Kinds 6 and 7 are spare codes; the block takes them and makes no pin writes.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Chance of an idle cycle on either side, in percent.
  localparam int unsigned IDLE_PCT = 28;
  // Random commands that make pin writes; spare kinds are not counted.
  localparam int unsigned RANDOM_CMDS = 450;
  // Quiet window at the end: covers the path through both queues with margin.
  localparam int unsigned DRAIN_CYCLES = 40;

  // ---------------------------------------------------------------------------
  // Scoreboard: tracks the pin levels and queues the expected run of writes
  // for every command transfer, then checks each result transfer in order.
  // ---------------------------------------------------------------------------
  class i2c_pin_scoreboard;
    logic scl_q;
    logic sda_q;
    res_t expected_writes[$];
    int unsigned mismatches;

    function new();
      scl_q = 1'b1;
      sda_q = 1'b1;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_writes.size();
    endfunction

    // one open-drain write: record the levels after it
    function void log_write(logic [7:0] rxb, logic rxa, logic fin);
      res_t w;
      w.scl = scl_q;
      w.sda = sda_q;
      w.rx_byte = rxb;
      w.rx_ack = rxa;
      w.last = fin;
      expected_writes.push_back(w);
    endfunction

    function void set_sda(logic v, logic fin);
      sda_q = v;
      log_write(8'h00, 1'b0, fin);
    endfunction

    function void set_scl(logic v, logic [7:0] rxb, logic rxa, logic fin);
      scl_q = v;
      log_write(rxb, rxa, fin);
    endfunction

    // expand one accepted command into its pin writes
    function void note_command(logic [2:0] kind, logic [7:0] tx, logic ack,
                               logic [7:0] lines);
      logic [7:0] acc;
      acc = 8'h00;
      case (kind)
        KIND_START: begin
          set_sda(1'b1, 1'b0);
          set_scl(1'b1, 8'h00, 1'b0, 1'b0);
          set_sda(1'b0, 1'b0);
          set_scl(1'b0, 8'h00, 1'b0, 1'b1);
        end
        KIND_STOP: begin
          set_sda(1'b0, 1'b0);
          set_scl(1'b1, 8'h00, 1'b0, 1'b0);
          set_sda(1'b1, 1'b1);
        end
        KIND_SEND: begin
          for (int i = 7; i >= 0; i--) begin
            set_sda(tx[i], 1'b0);
            set_scl(1'b1, 8'h00, 1'b0, 1'b0);
            set_scl(1'b0, 8'h00, 1'b0, i == 0);
          end
        end
        KIND_RECV: begin
          set_sda(1'b1, 1'b0);
          for (int i = 7; i >= 0; i--) begin
            set_scl(1'b1, 8'h00, 1'b0, 1'b0);
            acc[i] = lines[i];
            set_scl(1'b0, (i == 0) ? acc : 8'h00, 1'b0, i == 0);
          end
        end
        KIND_SACK: begin
          set_sda(ack, 1'b0);
          set_scl(1'b1, 8'h00, 1'b0, 1'b0);
          set_scl(1'b0, 8'h00, 1'b0, 1'b1);
        end
        KIND_RACK: begin
          set_sda(1'b1, 1'b0);
          set_scl(1'b1, 8'h00, 1'b0, 1'b0);
          set_scl(1'b0, 8'h00, lines[7], 1'b1);
        end
        default: ;  // spare kinds: no writes, levels hold
      endcase
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 100)
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task check_write(res_t got);
      res_t want;
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected pin write", int'(got), 0);
        return;
      end
      want = expected_writes.pop_front();
      if (got.scl !== want.scl)
        report_mismatch("scl", int'(got.scl), int'(want.scl));
      if (got.sda !== want.sda)
        report_mismatch("sda", int'(got.sda), int'(want.sda));
      if (got.rx_byte !== want.rx_byte)
        report_mismatch("rx_byte", int'(got.rx_byte), int'(want.rx_byte));
      if (got.rx_ack !== want.rx_ack)
        report_mismatch("rx_ack", int'(got.rx_ack), int'(want.rx_ack));
      if (got.last !== want.last)
        report_mismatch("last", int'(got.last), int'(want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [2:0] kind_i;
  logic [7:0] tx_byte_i;
  logic       ack_level_i;
  logic [7:0] line_bits_i;
  logic       empty;
  logic       pop;
  logic       scl_o;
  logic       sda_o;
  logic [7:0] rx_byte_o;
  logic       rx_ack_o;
  logic       last_o;

  i2c_pin_scoreboard sb;
  bit steady;               // set during the stretch with no idling on either side
  int unsigned busy_cmds;   // accepted commands of a real kind

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  i2c_master_bit_sequencer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .tx_byte_i  (tx_byte_i),
    .ack_level_i(ack_level_i),
    .line_bits_i(line_bits_i),
    .empty      (empty),
    .pop        (pop),
    .scl_o      (scl_o),
    .sda_o      (sda_o),
    .rx_byte_o  (rx_byte_o),
    .rx_ack_o   (rx_ack_o),
    .last_o     (last_o)
  );

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Called at a rising edge; returns at the edge of the transfer.
  // full is sampled on the falling edge, where it is settled, so the transfer
  // happens at the next rising edge exactly when full was low there.
  // push changes at most once per edge: if the next call does not idle, push
  // simply stays high for the following command.
  // ---------------------------------------------------------------------------
  task push_command(logic [2:0] kind, logic [7:0] tx, logic ack, logic [7:0] lines);
    bit took;
    while (idle_now()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    kind_i      <= kind;
    tx_byte_i   <= tx;
    ack_level_i <= ack;
    line_bits_i <= lines;
    do begin
      @(negedge clk_i);
      took = !full;
      @(posedge clk_i);
    end while (!took);
    sb.note_command(kind, tx, ack, lines);
    if (kind <= KIND_RACK) busy_cmds++;
  endtask

  // junk command: any kind, any field values
  task push_noise();
    push_command(3'($urandom_range(7)), rand_byte(), rand_bit(), rand_byte());
  endtask

  // A well-formed bus transaction with random content: start, address byte,
  // address ack, then data bytes with acks in the direction the R/W bit
  // gives, then stop (or a repeated start now and then, by leaving it off).
  task run_transaction();
    logic [7:0] addr;
    int unsigned nbytes;
    addr = rand_byte();
    nbytes = $urandom_range(1, 4);
    push_command(KIND_START, rand_byte(), rand_bit(), rand_byte());
    push_command(KIND_SEND, addr, rand_bit(), rand_byte());
    push_command(KIND_RACK, rand_byte(), rand_bit(), rand_byte());
    for (int unsigned n = 0; n < nbytes; n++) begin
      if (addr[0]) begin
        push_command(KIND_RECV, rand_byte(), rand_bit(), rand_byte());
        // master nacks the final byte, acks the rest; flipped sometimes
        push_command(KIND_SACK, rand_byte(),
                     (n == nbytes - 1) ^ ($urandom_range(7) == 0), rand_byte());
      end else begin
        push_command(KIND_SEND, rand_byte(), rand_bit(), rand_byte());
        push_command(KIND_RACK, rand_byte(), rand_bit(), rand_byte());
      end
    end
    if ($urandom_range(4) != 0)
      push_command(KIND_STOP, rand_byte(), rand_bit(), rand_byte());
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop changes only at rising edges; the fields are checked on
  // the falling edge before the edge that completes the transfer.
  // ---------------------------------------------------------------------------
  initial begin
    res_t got;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (pop && !empty) begin
        got.scl     = scl_o;
        got.sda     = sda_o;
        got.rx_byte = rx_byte_o;
        got.rx_ack  = rx_ack_o;
        got.last    = last_o;
        sb.check_write(got);
      end
      @(posedge clk_i);
      pop <= !idle_now();
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    steady      = 1'b0;
    busy_cmds   = 0;
    rst_ni      = 1'b0;
    push        = 1'b0;
    kind_i      = KIND_START;
    tx_byte_i   = 8'h00;
    ack_level_i = 1'b0;
    line_bits_i = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every kind, field extremes, spare kinds, ignored field bits
    push_command(KIND_START, 8'hff, 1'b1, 8'hff);
    push_command(KIND_SEND,  8'h00, 1'b1, 8'hff);
    push_command(KIND_SEND,  8'hff, 1'b0, 8'h00);
    push_command(KIND_SEND,  8'ha5, 1'b0, 8'h00);
    push_command(KIND_RACK,  8'hff, 1'b1, 8'h80);
    push_command(KIND_RACK,  8'h00, 1'b0, 8'h7f);
    push_command(KIND_RECV,  8'hff, 1'b1, 8'h00);
    push_command(KIND_SACK,  8'hff, 1'b0, 8'hff);
    push_command(KIND_RECV,  8'h00, 1'b0, 8'hff);
    push_command(KIND_SACK,  8'h00, 1'b1, 8'h00);
    push_command(KIND_RECV,  8'h3c, 1'b1, 8'h5a);
    push_command(KIND_SPARE_LO, 8'hff, 1'b1, 8'hff);
    push_command(KIND_SPARE_HI, 8'h00, 1'b0, 8'h00);
    push_command(KIND_STOP,  8'h00, 1'b1, 8'hff);
    push_command(KIND_STOP,  8'hff, 1'b0, 8'h00);
    push_command(KIND_SPARE_HI, 8'h81, 1'b1, 8'h18);
    push_command(KIND_START, 8'h00, 1'b0, 8'h00);
    push_command(KIND_START, 8'h5a, 1'b1, 8'ha5);

    // random: mostly well-formed transactions, the rest loose noise
    busy_cmds = 0;
    while (busy_cmds < RANDOM_CMDS) begin
      steady = (busy_cmds >= 180) && (busy_cmds < 260);
      if ($urandom_range(99) < 20) push_noise();
      else run_transaction();
    end
    steady = 1'b0;
    push <= 1'b0;

    // drain, then stay quiet long enough to catch stray writes
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest correct run (every command a full
  // 24-write send byte with both sides stalling).
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
sv/i2c_bseq_pkg.sv
sv/i2c_bseq_front.sv
sv/i2c_bseq_back.sv
sv/i2c_bseq_out_q.sv
sv/i2c_master_bit_sequencer_top.sv
sv/i2c_bseq_chk.sv
sim/i2c_master_bit_sequencer_top_test.sv
